// File: src/two_port_mac_learning_bridge_top_defines.svh
// assertion macros shared by the bridge rtl
`ifndef TWO_PORT_MAC_LEARNING_BRIDGE_TOP_DEFINES_SVH
`define TWO_PORT_MAC_LEARNING_BRIDGE_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TPMLB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define TPMLB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/tpmlb_pkg.sv
`default_nettype none

package tpmlb_pkg;

   localparam int MAC_W          = 48;
   localparam int AGE_W          = 16;
   localparam int AGED_W         = 7;
   localparam int CNT_W          = 32;
   localparam int NUM_COUNTERS   = 14;
   localparam int TYPES_PER_PORT = 7;

   localparam logic [MAC_W-1:0]  BROADCAST_MAC = '1;
   localparam logic [15:0]       HTTP_PORT     = 16'd80;
   localparam logic [AGED_W-1:0] AGED_MAX      = '1;
   localparam logic [AGE_W-1:0]  AGE_RESET     = 16'd300;

   typedef enum logic [1:0] {
      KIND_FRAME = 2'd0,
      KIND_TICK  = 2'd1,
      KIND_CLEAR = 2'd2,
      KIND_READ  = 2'd3
   } kind_type;

   // operation carried by the token walking the cell row
   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_LEARN  = 2'd1,
      OP_AGE    = 2'd2,
      OP_CLEAR  = 2'd3
   } tok_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_RESP
   } state_type;

   typedef struct packed {
      kind_type          kind;
      logic              ingress_port;
      logic [MAC_W-1:0]  src_mac;
      logic [MAC_W-1:0]  dst_mac;
      logic              has_arp;
      logic              has_ip;
      logic              has_tcp;
      logic              has_udp;
      logic              has_icmp;
      logic [15:0]       tcp_dst_port;
      logic [3:0]        counter_index;
   } req_type;

   typedef struct packed {
      logic              forward;
      logic              learned_new;
      logic              table_full;
      logic [AGED_W-1:0] aged_out;
      logic [CNT_W-1:0]  counter_value;
   } rsp_type;

   typedef struct packed {
      logic              valid;
      tok_op_type        op;
      logic              port;
      logic [MAC_W-1:0]  src_mac;
      logic [MAC_W-1:0]  dst_mac;
      logic [AGE_W-1:0]  age_limit;
      logic              src_hit;
      logic              dst_hit;
      logic              dst_port;
      logic              claimed;
      logic [AGED_W-1:0] aged;
   } token_type;

endpackage

`default_nettype wire

// File: src/two_port_mac_learning_bridge_top.sv
// channel   ports                               handshake
// request   start, busy, req_data               beat taken when start and not busy
// response  rsp_valid, rsp_data                 one-cycle strobe, cannot be held off
// csr       csr_valid, csr_ready, csr_data      written when valid and ready, only while idle
//
// one item at a time; a token walks the row of TABLE_DEPTH cells, one cell a cycle
// a known source, a tick or a clear walks the row once; an unknown source walks it
// a second time to learn; a counter read is answered without a walk
// busy stays high through the strobe; the next beat can be taken in the cycle after it
// synchronous reset empties the table, zeroes counters and sets age_limit to 300
`default_nettype none

`include "two_port_mac_learning_bridge_top_defines.svh"

module two_port_mac_learning_bridge_top #(
   parameter int TABLE_DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  tpmlb_pkg::req_type            req_data,
   output logic                          rsp_valid,
   output tpmlb_pkg::rsp_type            rsp_data,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [tpmlb_pkg::AGE_W-1:0] csr_data
);

   tpmlb_pkg::state_type            state_ff, state_in;
   tpmlb_pkg::token_type            launch_ff, launch_in;
   tpmlb_pkg::rsp_type              rsp_ff, rsp_in;
   logic [tpmlb_pkg::AGE_W-1:0]     age_limit_ff;
   tpmlb_pkg::token_type            chain_tok [TABLE_DEPTH+1];
   tpmlb_pkg::token_type            tail;
   logic                            bump, wipe;
   logic [tpmlb_pkg::CNT_W-1:0]     cnt_value;
   logic                            take;
   logic                            relearn;

   assign take    = start && !busy;
   assign tail    = chain_tok[TABLE_DEPTH];
   // a lookup that missed the source goes round again to claim a free cell
   assign relearn = tail.op == tpmlb_pkg::OP_LOOKUP && !tail.src_hit;

   assign chain_tok[0] = launch_ff;
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      tpmlb_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .up_tok (chain_tok[i]),
         .dn_tok (chain_tok[i+1])
      );
   end

   tpmlb_counters u_counters (
      .clock      (clock),
      .reset      (reset),
      .bump       (bump),
      .wipe       (wipe),
      .req        (req_data),
      .read_value (cnt_value)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tpmlb_pkg::ST_IDLE: begin
            if (take) begin
               state_in = (req_data.kind == tpmlb_pkg::KIND_READ) ?
                          tpmlb_pkg::ST_RESP : tpmlb_pkg::ST_WALK;
            end
         end
         tpmlb_pkg::ST_WALK: begin
            if (tail.valid && !relearn) begin
               state_in = tpmlb_pkg::ST_RESP;
            end
         end
         tpmlb_pkg::ST_RESP: begin
            state_in = tpmlb_pkg::ST_IDLE;
         end
         default: begin
            state_in = tpmlb_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      launch_in       = launch_ff;
      launch_in.valid = 1'b0;
      rsp_in          = rsp_ff;
      bump            = 1'b0;
      wipe            = 1'b0;
      unique case (state_ff)
         tpmlb_pkg::ST_IDLE: begin
            if (take) begin
               launch_in.port      = req_data.ingress_port;
               launch_in.src_mac   = req_data.src_mac;
               launch_in.dst_mac   = req_data.dst_mac;
               launch_in.age_limit = age_limit_ff;
               launch_in.src_hit   = 1'b0;
               launch_in.dst_hit   = 1'b0;
               launch_in.dst_port  = 1'b0;
               launch_in.claimed   = 1'b0;
               launch_in.aged      = '0;
               rsp_in              = '0;
               unique case (req_data.kind)
                  tpmlb_pkg::KIND_FRAME: begin
                     launch_in.valid = 1'b1;
                     launch_in.op    = tpmlb_pkg::OP_LOOKUP;
                     bump            = 1'b1;
                  end
                  tpmlb_pkg::KIND_TICK: begin
                     launch_in.valid = 1'b1;
                     launch_in.op    = tpmlb_pkg::OP_AGE;
                  end
                  tpmlb_pkg::KIND_CLEAR: begin
                     launch_in.valid = 1'b1;
                     launch_in.op    = tpmlb_pkg::OP_CLEAR;
                     wipe            = 1'b1;
                  end
                  tpmlb_pkg::KIND_READ: begin
                     rsp_in.counter_value = cnt_value;
                  end
               endcase
            end
         end
         tpmlb_pkg::ST_WALK: begin
            if (tail.valid) begin
               if (relearn) begin
                  launch_in       = tail;
                  launch_in.op    = tpmlb_pkg::OP_LEARN;
                  launch_in.valid = 1'b1;
               end else begin
                  rsp_in = '0;
                  unique case (tail.op) inside
                     tpmlb_pkg::OP_LOOKUP, tpmlb_pkg::OP_LEARN: begin
                        // a new source equal to the destination counts as found on ingress
                        rsp_in.forward     = tail.dst_mac == tpmlb_pkg::BROADCAST_MAC ||
                                             (tail.dst_hit ? tail.dst_port != tail.port :
                                              !(tail.dst_mac == tail.src_mac && tail.claimed));
                        rsp_in.learned_new = tail.claimed;
                        rsp_in.table_full  = tail.op == tpmlb_pkg::OP_LEARN && !tail.claimed;
                     end
                     tpmlb_pkg::OP_AGE: begin
                        rsp_in.aged_out = tail.aged;
                     end
                     tpmlb_pkg::OP_CLEAR: begin
                        rsp_in.aged_out = '0;
                     end
                  endcase
               end
            end
         end
         tpmlb_pkg::ST_RESP: begin
            rsp_in = rsp_ff;
         end
         default: begin
            rsp_in = rsp_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= tpmlb_pkg::ST_IDLE;
         launch_ff.valid <= 1'b0;
         age_limit_ff    <= tpmlb_pkg::AGE_RESET;
      end else begin
         state_ff        <= state_in;
         launch_ff.valid <= launch_in.valid;
         if (csr_valid && csr_ready) begin
            age_limit_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      launch_ff.op        <= launch_in.op;
      launch_ff.port      <= launch_in.port;
      launch_ff.src_mac   <= launch_in.src_mac;
      launch_ff.dst_mac   <= launch_in.dst_mac;
      launch_ff.age_limit <= launch_in.age_limit;
      launch_ff.src_hit   <= launch_in.src_hit;
      launch_ff.dst_hit   <= launch_in.dst_hit;
      launch_ff.dst_port  <= launch_in.dst_port;
      launch_ff.claimed   <= launch_in.claimed;
      launch_ff.aged      <= launch_in.aged;
      rsp_ff              <= rsp_in;
   end

   assign busy      = state_ff != tpmlb_pkg::ST_IDLE;
   // a register write never lands on the edge that takes a beat
   assign csr_ready = !busy && !start;
   assign rsp_valid = state_ff == tpmlb_pkg::ST_RESP;
   assign rsp_data  = rsp_ff;

   `TPMLB_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid, !rsp_valid,
      "response strobe longer than one cycle")
   `TPMLB_ASSERT_NOW(a_tail_in_walk, clock, reset, tail.valid,
      state_ff == tpmlb_pkg::ST_WALK, "token left the cell row outside a walk")
   `TPMLB_ASSERT_NOW(a_one_token, clock, reset, launch_ff.valid, !tail.valid,
      "two tokens in the cell row")
   `TPMLB_ASSERT_NOW(a_learn_or_full, clock, reset, rsp_valid,
      !(rsp_data.learned_new && rsp_data.table_full), "learned and full on one frame")
   `TPMLB_ASSERT_NEXT(a_take_busy, clock, reset, take, busy,
      "accepted beat did not raise busy")

endmodule

`default_nettype wire

// File: src/tpmlb_cell.sv
`default_nettype none

`include "two_port_mac_learning_bridge_top_defines.svh"

module tpmlb_cell (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  tpmlb_pkg::token_type      up_tok,
   output tpmlb_pkg::token_type      dn_tok
);

   logic                           valid_ff, valid_in;
   logic [tpmlb_pkg::MAC_W-1:0]    mac_ff, mac_in;
   logic                           port_ff, port_in;
   logic [tpmlb_pkg::AGE_W-1:0]    age_ff, age_in;
   tpmlb_pkg::token_type           dn_tok_ff, dn_tok_in;

   always_comb begin
      valid_in  = valid_ff;
      mac_in    = mac_ff;
      port_in   = port_ff;
      age_in    = age_ff;
      dn_tok_in = up_tok;
      if (up_tok.valid) begin
         unique case (up_tok.op)
            tpmlb_pkg::OP_LOOKUP: begin
               if (valid_ff && mac_ff == up_tok.src_mac) begin
                  age_in            = up_tok.age_limit;
                  dn_tok_in.src_hit = 1'b1;
               end
               if (valid_ff && mac_ff == up_tok.dst_mac) begin
                  dn_tok_in.dst_hit  = 1'b1;
                  dn_tok_in.dst_port = port_ff;
               end
            end
            tpmlb_pkg::OP_LEARN: begin
               // first free cell takes the address
               if (!valid_ff && !up_tok.claimed) begin
                  valid_in          = 1'b1;
                  mac_in            = up_tok.src_mac;
                  port_in           = up_tok.port;
                  age_in            = up_tok.age_limit;
                  dn_tok_in.claimed = 1'b1;
               end
            end
            tpmlb_pkg::OP_AGE: begin
               if (valid_ff) begin
                  if (age_ff <= 16'd1) begin
                     valid_in = 1'b0;
                     if (up_tok.aged != tpmlb_pkg::AGED_MAX) begin
                        dn_tok_in.aged = up_tok.aged + 7'd1;
                     end
                  end else begin
                     age_in = age_ff - 16'd1;
                  end
               end
            end
            tpmlb_pkg::OP_CLEAR: begin
               valid_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff        <= 1'b0;
         dn_tok_ff.valid <= 1'b0;
      end else begin
         valid_ff        <= valid_in;
         dn_tok_ff.valid <= dn_tok_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      mac_ff              <= mac_in;
      port_ff             <= port_in;
      age_ff              <= age_in;
      dn_tok_ff.op        <= dn_tok_in.op;
      dn_tok_ff.port      <= dn_tok_in.port;
      dn_tok_ff.src_mac   <= dn_tok_in.src_mac;
      dn_tok_ff.dst_mac   <= dn_tok_in.dst_mac;
      dn_tok_ff.age_limit <= dn_tok_in.age_limit;
      dn_tok_ff.src_hit   <= dn_tok_in.src_hit;
      dn_tok_ff.dst_hit   <= dn_tok_in.dst_hit;
      dn_tok_ff.dst_port  <= dn_tok_in.dst_port;
      dn_tok_ff.claimed   <= dn_tok_in.claimed;
      dn_tok_ff.aged      <= dn_tok_in.aged;
   end

   assign dn_tok = dn_tok_ff;

   `TPMLB_ASSERT_NEXT(a_cell_claim, clock, reset,
      up_tok.valid && up_tok.op == tpmlb_pkg::OP_LEARN && !up_tok.claimed && !valid_ff,
      valid_ff && dn_tok_ff.claimed, "free cell did not take the learned address")
   `TPMLB_ASSERT_NEXT(a_cell_keep_claimed, clock, reset,
      up_tok.valid && up_tok.op == tpmlb_pkg::OP_LEARN && up_tok.claimed,
      dn_tok_ff.claimed && $stable(valid_ff), "claimed token changed a later cell")
   `TPMLB_ASSERT_NEXT(a_cell_clear, clock, reset,
      up_tok.valid && up_tok.op == tpmlb_pkg::OP_CLEAR,
      !valid_ff, "cell still valid after clear")

endmodule

`default_nettype wire

// File: src/tpmlb_counters.sv
`default_nettype none

`include "two_port_mac_learning_bridge_top_defines.svh"

module tpmlb_counters (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        bump,
   input  wire logic                        wipe,
   input  tpmlb_pkg::req_type               req,
   output logic [tpmlb_pkg::CNT_W-1:0]      read_value
);

   logic [tpmlb_pkg::CNT_W-1:0] cnt_ff [tpmlb_pkg::NUM_COUNTERS];
   logic [tpmlb_pkg::CNT_W-1:0] cnt_in [tpmlb_pkg::NUM_COUNTERS];
   logic [tpmlb_pkg::TYPES_PER_PORT-1:0] type_hit;

   // eth, arp, ip, tcp, udp, icmp, http
   assign type_hit = {req.has_tcp && req.tcp_dst_port == tpmlb_pkg::HTTP_PORT,
                      req.has_icmp, req.has_udp, req.has_tcp,
                      req.has_ip, req.has_arp, 1'b1};

   for (genvar i = 0; i < tpmlb_pkg::NUM_COUNTERS; i++) begin : g_cnt
      localparam int PORT_SEL = i / tpmlb_pkg::TYPES_PER_PORT;
      localparam int TYPE_SEL = i % tpmlb_pkg::TYPES_PER_PORT;

      always_comb begin
         cnt_in[i] = cnt_ff[i];
         if (wipe) begin
            cnt_in[i] = '0;
         end else if (bump && req.ingress_port == 1'(PORT_SEL) && type_hit[TYPE_SEL]) begin
            cnt_in[i] = cnt_ff[i] + 32'd1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cnt_ff[i] <= '0;
         end else begin
            cnt_ff[i] <= cnt_in[i];
         end
      end
   end

   always_comb begin
      read_value = '0;
      if (req.counter_index < 4'(tpmlb_pkg::NUM_COUNTERS)) begin
         read_value = cnt_ff[req.counter_index];
      end
   end

   `TPMLB_ASSERT_NEXT(a_cnt_wipe, clock, reset, wipe,
      cnt_ff[0] == '0 && cnt_ff[tpmlb_pkg::NUM_COUNTERS-1] == '0,
      "counters not zero after clear")
   `TPMLB_ASSERT_NOW(a_cnt_excl, clock, reset, wipe, !bump,
      "clear and frame count in the same cycle")
   `TPMLB_ASSERT_NEXT(a_cnt_eth, clock, reset, bump && !req.ingress_port,
      cnt_ff[0] == $past(cnt_ff[0]) + 32'd1, "ethernet count of first port missed a frame")

endmodule

`default_nettype wire
